[src/binary_packet_validator_macros.svh]
// Assertion macros shared by the validator RTL
`ifndef BINARY_PACKET_VALIDATOR_MACROS_SVH
`define BINARY_PACKET_VALIDATOR_MACROS_SVH

// same-cycle implication
`define BPV_ASSERT_IMPL(label, clock, resetn, pre, post, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BPV_ASSERT_NEXT(label, clock, resetn, pre, post, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/bpv_pkg.sv]
// Types and constants of the binary packet validator
package bpv_pkg;

    localparam int unsigned HDR_LEN   = 16;
    localparam int unsigned COUNT_W   = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd16;
    localparam logic [COUNT_W-1:0] MIN_BYTES = 17'd20;

    localparam logic [7:0] MAGIC_0 = 8'h49;
    localparam logic [7:0] MAGIC_1 = 8'h47;
    localparam logic [7:0] MAGIC_2 = 8'h57;
    localparam logic [7:0] MAGIC_3 = 8'h31;
    localparam logic [7:0] VERSION_ONE = 8'h01;
    localparam logic [7:0] KIND_REGISTRATION = 8'h01;
    localparam logic [7:0] KIND_UNLOCK = 8'h02;
    localparam logic [7:0] PRINT_LOW = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    localparam logic [7:0]  MAX_ID_LENGTH_RESET = 8'd16;
    localparam logic [15:0] UNLOCK_FIRST_RESET  = 16'd7421;
    localparam logic [15:0] UNLOCK_SECOND_RESET = 16'd3390;

    typedef logic [1:0]  cfg_addr_t;
    typedef logic [15:0] cfg_data_t;

    localparam cfg_addr_t CFG_MAX_ID_LENGTH  = 2'd0;
    localparam cfg_addr_t CFG_UNLOCK_FIRST   = 2'd1;
    localparam cfg_addr_t CFG_UNLOCK_SECOND  = 2'd2;

    typedef enum logic [3:0] {
        VERDICT_ACCEPT      = 4'd0,
        VERDICT_SHORT       = 4'd1,
        VERDICT_MAGIC       = 4'd2,
        VERDICT_VERSION     = 4'd3,
        VERDICT_TYPE        = 4'd4,
        VERDICT_FLAGS       = 4'd5,
        VERDICT_RESERVED    = 4'd6,
        VERDICT_SIZE        = 4'd7,
        VERDICT_ID_PAYLOAD  = 4'd8,
        VERDICT_CHECKSUM    = 4'd9,
        VERDICT_UNPRINTABLE = 4'd10,
        VERDICT_ID_LONG     = 4'd11,
        VERDICT_UNLOCK      = 4'd12
    } verdict_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        byte_count;
        logic [HDR_LEN-1:0][7:0]   header_bytes;
        logic [31:0]               running_sum;
        logic [31:0]               tail_bytes;
        logic                      id_unprintable;
    } pkt_state_t;

    typedef struct packed {
        logic [7:0]  max_id_length;
        logic [15:0] unlock_code_first;
        logic [15:0] unlock_code_second;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [7:0]  packet_kind;
        logic [7:0]  id_length;
        logic [15:0] payload_length;
    } result_t;

endpackage

[src/bpv_ifs.sv]
// Handshake interfaces of the binary packet validator
interface bpv_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface bpv_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic [7:0]  packet_kind;
    logic [7:0]  id_length;
    logic [15:0] payload_length;

    modport source (output valid, output verdict, output packet_kind, output id_length,
                    output payload_length, input ready);
    modport sink (input valid, input verdict, input packet_kind, input id_length,
                  input payload_length, output ready);
endinterface

interface bpv_cfg_if;
    logic               valid;
    logic               ready;
    bpv_pkg::cfg_addr_t addr;
    bpv_pkg::cfg_data_t data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

[src/bpv_judge.sv]
// Verdict logic: first failing check of a completed packet
module bpv_judge (
    input  bpv_pkg::pkt_state_t state,
    input  bpv_pkg::cfg_t       cfg,
    output bpv_pkg::result_t    result
);

    logic [7:0]  kind;
    logic [7:0]  idlen;
    logic [15:0] plen;
    logic [15:0] reserved_word;
    logic [15:0] unlock_first;
    logic [15:0] unlock_second;
    logic [9:0]  tail_sum;
    logic [31:0] computed;
    logic [bpv_pkg::COUNT_W-1:0] expected_count;
    bpv_pkg::verdict_t verdict;

    assign kind          = state.header_bytes[5];
    assign idlen         = state.header_bytes[6];
    assign plen          = {state.header_bytes[9], state.header_bytes[8]};
    assign unlock_first  = {state.header_bytes[11], state.header_bytes[10]};
    assign unlock_second = {state.header_bytes[13], state.header_bytes[12]};
    assign reserved_word = {state.header_bytes[15], state.header_bytes[14]};

    assign tail_sum = {2'b00, state.tail_bytes[7:0]} + {2'b00, state.tail_bytes[15:8]}
                    + {2'b00, state.tail_bytes[23:16]} + {2'b00, state.tail_bytes[31:24]};
    assign computed = state.running_sum - {22'd0, tail_sum};
    assign expected_count = {1'b0, plen} + bpv_pkg::MIN_BYTES;

    always_comb
    begin
        if (state.byte_count < bpv_pkg::MIN_BYTES)
            verdict = bpv_pkg::VERDICT_SHORT;
        else if (state.header_bytes[0] != bpv_pkg::MAGIC_0
                 || state.header_bytes[1] != bpv_pkg::MAGIC_1
                 || state.header_bytes[2] != bpv_pkg::MAGIC_2
                 || state.header_bytes[3] != bpv_pkg::MAGIC_3)
            verdict = bpv_pkg::VERDICT_MAGIC;
        else if (state.header_bytes[4] != bpv_pkg::VERSION_ONE)
            verdict = bpv_pkg::VERDICT_VERSION;
        else if (kind != bpv_pkg::KIND_REGISTRATION && kind != bpv_pkg::KIND_UNLOCK)
            verdict = bpv_pkg::VERDICT_TYPE;
        else if (state.header_bytes[7] != 8'd0)
            verdict = bpv_pkg::VERDICT_FLAGS;
        else if (reserved_word != 16'd0)
            verdict = bpv_pkg::VERDICT_RESERVED;
        else if (state.byte_count != expected_count)
            verdict = bpv_pkg::VERDICT_SIZE;
        else if (kind == bpv_pkg::KIND_REGISTRATION && plen < {8'd0, idlen})
            verdict = bpv_pkg::VERDICT_ID_PAYLOAD;
        else if (computed != state.tail_bytes)
            verdict = bpv_pkg::VERDICT_CHECKSUM;
        else if (kind == bpv_pkg::KIND_REGISTRATION)
        begin
            if (idlen != 8'd0 && state.id_unprintable)
                verdict = bpv_pkg::VERDICT_UNPRINTABLE;
            else if (idlen > cfg.max_id_length)
                verdict = bpv_pkg::VERDICT_ID_LONG;
            else
                verdict = bpv_pkg::VERDICT_ACCEPT;
        end
        else if (unlock_first != cfg.unlock_code_first
                 || unlock_second != cfg.unlock_code_second)
            verdict = bpv_pkg::VERDICT_UNLOCK;
        else
            verdict = bpv_pkg::VERDICT_ACCEPT;
    end

    always_comb
    begin
        result.verdict        = verdict;
        result.packet_kind    = kind;
        result.id_length      = idlen;
        result.payload_length = plen;
    end

endmodule

[src/binary_packet_validator.sv]
// Binary packet validator top level: byte intake, packet state, result register
// Takes one packet byte per cycle, with no gap between packets, unless the input is held
// off as described below. Each byte updates the byte count, header copy, running sum,
// last-four-byte window and id check in the cycle it is transferred. After the final
// byte, the verdict is formed from the registered packet state and written to the
// result register once that register is free. The input holds off only while that
// verdict is waiting and the result register is full and not being taken.
// Configuration writes are taken in every cycle.
`include "binary_packet_validator_macros.svh"

module binary_packet_validator (
    input logic clk,
    input logic rst_n,
    bpv_pkt_if.sink   pkt,
    bpv_res_if.source res,
    bpv_cfg_if.sink   cfg
);

    bpv_pkg::pkt_state_t state_reg, state_next, base;
    bpv_pkg::cfg_t       cfg_reg, cfg_next;
    bpv_pkg::result_t    result_reg, result_next, judged;
    logic                pending_reg, pending_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                clear_now;
    logic                pkt_accept;
    logic [bpv_pkg::COUNT_W-1:0] id_offset;

    bpv_judge u_judge (
        .state  (state_reg),
        .cfg    (cfg_reg),
        .result (judged)
    );

    assign out_free   = !out_valid_reg || res.ready;
    assign clear_now  = pending_reg && out_free;
    assign pkt.ready  = !pending_reg || out_free;
    assign pkt_accept = pkt.valid && pkt.ready;
    assign cfg.ready  = 1'b1;

    assign res.valid          = out_valid_reg;
    assign res.verdict        = result_reg.verdict;
    assign res.packet_kind    = result_reg.packet_kind;
    assign res.id_length      = result_reg.id_length;
    assign res.payload_length = result_reg.payload_length;

    assign base      = clear_now ? '0 : state_reg;
    assign id_offset = base.byte_count - bpv_pkg::HDR_BYTES;

    always_comb
    begin
        state_next = base;
        if (pkt_accept)
        begin
            if (base.byte_count < bpv_pkg::HDR_BYTES)
                state_next.header_bytes[base.byte_count[3:0]] = pkt.data_byte;
            else if (id_offset < {9'd0, base.header_bytes[6]})
            begin
                if (pkt.data_byte < bpv_pkg::PRINT_LOW || pkt.data_byte > bpv_pkg::PRINT_HIGH)
                    state_next.id_unprintable = 1'b1;
            end
            state_next.running_sum = base.running_sum + {24'd0, pkt.data_byte};
            state_next.tail_bytes  = {pkt.data_byte, base.tail_bytes[31:8]};
            if (base.byte_count != bpv_pkg::COUNT_MAX)
                state_next.byte_count = base.byte_count + 17'd1;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (clear_now)
            pending_next = 1'b0;
        if (pkt_accept && pkt.is_last)
            pending_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (clear_now)
        begin
            out_valid_next = 1'b1;
            result_next    = judged;
        end
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                bpv_pkg::CFG_MAX_ID_LENGTH: cfg_next.max_id_length      = cfg.data[7:0];
                bpv_pkg::CFG_UNLOCK_FIRST:  cfg_next.unlock_code_first  = cfg.data;
                bpv_pkg::CFG_UNLOCK_SECOND: cfg_next.unlock_code_second = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.max_id_length      <= bpv_pkg::MAX_ID_LENGTH_RESET;
            cfg_reg.unlock_code_first  <= bpv_pkg::UNLOCK_FIRST_RESET;
            cfg_reg.unlock_code_second <= bpv_pkg::UNLOCK_SECOND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `BPV_ASSERT_IMPL(a_stall_when_full, clk, rst_n, pending_reg && !out_free, !pkt.ready, "input taken while verdict blocked")
    `BPV_ASSERT_NEXT(a_last_sets_pending, clk, rst_n, pkt_accept && pkt.is_last, pending_reg, "final byte did not raise pending verdict")
    `BPV_ASSERT_NEXT(a_pending_delivers, clk, rst_n, clear_now, out_valid_reg, "pending verdict not written to result register")
    `BPV_ASSERT_NEXT(a_clear_after_verdict, clk, rst_n, clear_now && !pkt_accept, state_reg == '0, "packet state not cleared after verdict")

endmodule
